// ===== src/periodic_interrupt_timer_4ch_defines.svh =====
// Assertion helpers used by the timer checker.
`ifndef PERIODIC_INTERRUPT_TIMER_4CH_DEFINES_SVH
`define PERIODIC_INTERRUPT_TIMER_4CH_DEFINES_SVH

// Condition must hold on every clock edge outside reset.
`define PIT4_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define PIT4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pit4_pkg.sv =====
package pit4_pkg;

  // Command codes of an input beat
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Global register offsets
  localparam logic [8:0] OFS_MCR      = 9'h000;
  localparam logic [8:0] OFS_LTMR_HI  = 9'h0E0;
  localparam logic [8:0] OFS_LTMR_LO  = 9'h0E4;
  localparam logic [8:0] OFS_RSVD0    = 9'h0E8;
  localparam logic [8:0] OFS_RSVD1    = 9'h0EC;
  localparam logic [8:0] OFS_RTI_LD   = 9'h0F0;
  localparam logic [8:0] OFS_RTI_CV   = 9'h0F4;
  localparam logic [8:0] OFS_RTI_CTRL = 9'h0F8;
  localparam logic [8:0] OFS_RTI_FLG  = 9'h0FC;

  // Per-channel register within a 0x10 slot starting at 0x100
  localparam logic [3:0] REG_LDVAL = 4'h0;
  localparam logic [3:0] REG_CVAL  = 4'h4;
  localparam logic [3:0] REG_TCTRL = 4'h8;
  localparam logic [3:0] REG_TFLG  = 4'hC;

  // Control bit positions
  localparam int BIT_TEN  = 0;
  localparam int BIT_TIE  = 1;
  localparam int BIT_CHN  = 2;
  localparam int BIT_MDIS = 1;

  localparam int CTRL_W = 3;
  localparam logic [CTRL_W-1:0] MCR_RESET = 3'b010;

  typedef logic [CTRL_W-1:0] ctrl_t;

endpackage

// ===== src/periodic_interrupt_timer_4ch.sv =====
// The result of a beat is registered on the edge that accepts the beat.
// Throughput: one beat per cycle; input stalls only while a result waits on out_ready.
// A tick updates all counters in one pass; the expiry chain ripples through
// the channels combinationally, so the whole chain settles in that cycle.
// Reset (rst, synchronous): module disabled, all counters, loads, flags cleared.
module periodic_interrupt_timer_4ch import pit4_pkg::*; #(
  parameter int CHANNELS     = 4,
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [8:0]  reg_offset,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [3:0]  irq_lines,
  output logic        unmapped
);

  localparam int HI_CH = (CHANNELS > 1) ? 1 : 0;
  localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);
  localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  // Timer state
  ctrl_t       mode_control,       mode_control_next;
  cnt_t        reload_value  [CHANNELS];
  cnt_t        reload_value_next [CHANNELS];
  cnt_t        count_value   [CHANNELS];
  cnt_t        count_value_next  [CHANNELS];
  ctrl_t       channel_control [CHANNELS];
  ctrl_t       channel_control_next [CHANNELS];
  logic [CHANNELS-1:0] channel_flag, channel_flag_next;
  cnt_t        lifetime_low_latch, lifetime_low_latch_next;
  cnt_t        rti_reload,  rti_reload_next;
  cnt_t        rti_count,   rti_count_next;
  ctrl_t       rti_control, rti_control_next;
  logic        rti_flag,    rti_flag_next;

  // Result of the current beat
  logic [31:0] rd_next;
  logic [3:0]  irq_next;
  logic        bad_next;

  logic in_accept;
  logic in_block;
  logic below;
  logic expire;

  function automatic cnt_t start_val(input cnt_t ld);
    return (ld == '0) ? CNT_ONE : ld;
  endfunction

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign in_block  = reg_offset[8] && (reg_offset[7:4] < CH_LIMIT);

  // Next state and result of one beat
  always_comb begin
    mode_control_next       = mode_control;
    reload_value_next       = reload_value;
    count_value_next        = count_value;
    channel_control_next    = channel_control;
    channel_flag_next       = channel_flag;
    lifetime_low_latch_next = lifetime_low_latch;
    rti_reload_next         = rti_reload;
    rti_count_next          = rti_count;
    rti_control_next        = rti_control;
    rti_flag_next           = rti_flag;
    rd_next                 = '0;
    bad_next                = 1'b0;
    below                   = 1'b0;
    expire                  = 1'b0;

    unique case (cmd)
      CMD_TICK: begin
        // chained channels advance only when the one below expires
        for (int n = 0; n < CHANNELS; n++) begin
          expire = 1'b0;
          if (channel_control[n][BIT_TEN] && !mode_control[BIT_MDIS] &&
              (n == 0 || !channel_control[n][BIT_CHN] || below)) begin
            if (count_value[n] <= CNT_ONE) begin
              channel_flag_next[n] = 1'b1;
              count_value_next[n]  = start_val(reload_value[n]);
              expire               = 1'b1;
            end else begin
              count_value_next[n] = count_value[n] - CNT_ONE;
            end
          end
          below = expire;
        end
        if (rti_control[BIT_TEN] && !mode_control[BIT_MDIS]) begin
          if (rti_count <= CNT_ONE) begin
            rti_flag_next  = 1'b1;
            rti_count_next = start_val(rti_reload);
          end else begin
            rti_count_next = rti_count - CNT_ONE;
          end
        end
      end

      CMD_READ: begin
        if (in_block) begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (reg_offset[7:4] == 4'(n)) begin
              unique case (reg_offset[3:0])
                REG_LDVAL: rd_next = 32'(reload_value[n]);
                REG_CVAL:  rd_next = 32'(count_value[n]);
                REG_TCTRL: rd_next = 32'(channel_control[n]);
                REG_TFLG:  rd_next = 32'(channel_flag[n]);
                default:   bad_next = 1'b1;
              endcase
            end
          end
        end else begin
          unique case (reg_offset)
            OFS_MCR: rd_next = 32'(mode_control);
            OFS_LTMR_HI: begin
              // high word read latches counter 0 for the low word
              lifetime_low_latch_next = count_value[0];
              rd_next = (CHANNELS > 1) ? 32'(count_value[HI_CH]) : '0;
            end
            OFS_LTMR_LO:  rd_next = 32'(lifetime_low_latch);
            OFS_RSVD0:    rd_next = '0;
            OFS_RSVD1:    rd_next = '0;
            OFS_RTI_LD:   rd_next = 32'(rti_reload);
            OFS_RTI_CV:   rd_next = 32'(rti_count);
            OFS_RTI_CTRL: rd_next = 32'(rti_control);
            OFS_RTI_FLG:  rd_next = 32'(rti_flag);
            default:      bad_next = 1'b1;
          endcase
        end
      end

      CMD_WRITE: begin
        if (in_block) begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (reg_offset[7:4] == 4'(n)) begin
              unique case (reg_offset[3:0])
                REG_LDVAL: begin
                  reload_value_next[n] = write_data[COUNTER_BITS-1:0];
                  count_value_next[n]  = start_val(write_data[COUNTER_BITS-1:0]);
                end
                REG_TCTRL: begin
                  channel_control_next[n] = write_data[CTRL_W-1:0];
                  if (write_data[BIT_TEN]) begin
                    channel_flag_next[n] = 1'b0;
                    if (!mode_control[BIT_MDIS]) begin
                      count_value_next[n] = start_val(reload_value[n]);
                    end
                  end
                end
                REG_TFLG: begin
                  if (write_data[0]) begin
                    channel_flag_next[n] = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end else begin
          unique case (reg_offset)
            OFS_MCR: begin
              mode_control_next = write_data[CTRL_W-1:0];
              if (!write_data[BIT_MDIS]) begin
                for (int n = 0; n < CHANNELS; n++) begin
                  if (channel_control[n][BIT_TEN]) begin
                    count_value_next[n] = start_val(reload_value[n]);
                  end
                end
              end
            end
            OFS_RSVD0: ;
            OFS_RSVD1: ;
            OFS_RTI_LD: begin
              rti_reload_next = write_data[COUNTER_BITS-1:0];
              if (rti_control[BIT_TEN]) begin
                rti_count_next = start_val(write_data[COUNTER_BITS-1:0]);
              end
            end
            OFS_RTI_CTRL: begin
              rti_control_next = write_data[CTRL_W-1:0];
              if (write_data[BIT_TEN] && !mode_control[BIT_MDIS]) begin
                rti_count_next = start_val(rti_reload);
              end
            end
            OFS_RTI_FLG: begin
              if (write_data[0]) begin
                rti_flag_next = 1'b0;
              end
            end
            default: bad_next = 1'b1;
          endcase
        end
      end

      default: ;
    endcase

    // interrupt lines from the updated state
    irq_next = '0;
    for (int n = 0; n < CHANNELS && n < 4; n++) begin
      irq_next[n] = channel_control_next[n][BIT_TIE] && channel_flag_next[n];
    end
    irq_next[0] = irq_next[0] || (rti_control_next[BIT_TIE] && rti_flag_next);
  end

  // State update on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_control       <= MCR_RESET;
      channel_flag       <= '0;
      lifetime_low_latch <= '0;
      rti_reload         <= '0;
      rti_count          <= '0;
      rti_control        <= '0;
      rti_flag           <= 1'b0;
      for (int n = 0; n < CHANNELS; n++) begin
        reload_value[n]    <= '0;
        count_value[n]     <= '0;
        channel_control[n] <= '0;
      end
    end else if (in_accept) begin
      mode_control       <= mode_control_next;
      reload_value       <= reload_value_next;
      count_value        <= count_value_next;
      channel_control    <= channel_control_next;
      channel_flag       <= channel_flag_next;
      lifetime_low_latch <= lifetime_low_latch_next;
      rti_reload         <= rti_reload_next;
      rti_count          <= rti_count_next;
      rti_control        <= rti_control_next;
      rti_flag           <= rti_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data <= rd_next;
      irq_lines <= irq_next;
      unmapped  <= bad_next;
    end
  end

endmodule

// ===== src/pit4_checker.sv =====
`include "periodic_interrupt_timer_4ch_defines.svh"

module pit4_checker import pit4_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        unmapped
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // An empty result register never holds off the input
  `PIT4_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no result pending")

  // Only reads return data
  `PIT4_ASSERT_NEXT(a_nonread_zero, in_beat && cmd != CMD_READ, out_valid && read_data == 32'd0, "non-read beat returned data")

  // A tick never reports an unmapped access
  `PIT4_ASSERT_NEXT(a_tick_mapped, in_beat && cmd == CMD_TICK, out_valid && !unmapped, "tick flagged as unmapped")

  // A stalled result holds
  `PIT4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(unmapped), "stalled result changed")

endmodule

bind periodic_interrupt_timer_4ch pit4_checker u_pit4_checker (.*);

// ===== test/periodic_interrupt_timer_4ch_test.sv =====
`timescale 1ns / 1ps

module periodic_interrupt_timer_4ch_test;
  import pit4_pkg::*;

  localparam int NCH = 4;
  localparam logic [8:0] CH_BASE = 9'h100;
  localparam int CH_STRIDE = 16;
  localparam logic [8:0] CH_END = CH_BASE + 9'(NCH * CH_STRIDE);
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int NUM_BEATS = 1100;
  localparam int QUIET_TAIL = 120;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [8:0]  ofs;
    logic [31:0] data;
  } bus_beat_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [3:0]  irq;
    logic        bad;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_TICK;
  logic [8:0]  reg_offset = '0;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic [3:0]  irq_lines;
  logic        unmapped;

  bus_beat_t     access_q[$];
  timer_result_t reply_q[$];

  int total_beats = 0;
  int beats_loaded = 0;
  int beats_taken = 0;
  int replies_seen = 0;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  logic [3:0] ch_regs [4] = '{REG_LDVAL, REG_CVAL, REG_TCTRL, REG_TFLG};
  logic [8:0] glob_regs [9] = '{OFS_MCR, OFS_LTMR_HI, OFS_LTMR_LO, OFS_RSVD0, OFS_RSVD1,
                               OFS_RTI_LD, OFS_RTI_CV, OFS_RTI_CTRL, OFS_RTI_FLG};

  periodic_interrupt_timer_4ch u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .irq_lines  (irq_lines),
    .unmapped   (unmapped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Timer state as predicted by the testbench
  // ---------------------------------------------------------------------------
  ctrl_t       mcr_r;
  logic [31:0] ldval_r [NCH];
  logic [31:0] cval_r [NCH];
  ctrl_t       tctrl_r [NCH];
  logic        tflg_r [NCH];
  logic [31:0] ltmr_latch_r;
  logic [31:0] rti_ldval_r;
  logic [31:0] rti_cval_r;
  ctrl_t       rti_tctrl_r;
  logic        rti_tflg_r;

  function automatic void clear_timer();
    int n;
    mcr_r = MCR_RESET;
    for (n = 0; n < NCH; n++) begin
      ldval_r[n] = '0;
      cval_r[n]  = '0;
      tctrl_r[n] = '0;
      tflg_r[n]  = 1'b0;
    end
    ltmr_latch_r = '0;
    rti_ldval_r  = '0;
    rti_cval_r   = '0;
    rti_tctrl_r  = '0;
    rti_tflg_r   = 1'b0;
  endfunction

  // a zero load still gives a period of one tick
  function automatic logic [31:0] start_count(input logic [31:0] ld);
    return (ld == '0) ? 32'd1 : ld;
  endfunction

  function automatic bit runs_now(input ctrl_t c);
    return c[BIT_TEN] && !mcr_r[BIT_MDIS];
  endfunction

  // one step of a down-counter; returns 1 on expiry
  function automatic bit count_down(inout logic [31:0] cv, inout logic flg,
                                    input logic [31:0] ld);
    if (cv <= 32'd1) begin
      flg = 1'b1;
      cv = start_count(ld);
      return 1'b1;
    end
    cv = cv - 32'd1;
    return 1'b0;
  endfunction

  // chained channels advance only when the one below expired this tick
  function automatic void tick_all();
    bit carry;
    bit hit;
    int n;
    carry = 1'b0;
    for (n = 0; n < NCH; n++) begin
      hit = 1'b0;
      if (runs_now(tctrl_r[n]) && (n == 0 || !tctrl_r[n][BIT_CHN] || carry))
        hit = count_down(cval_r[n], tflg_r[n], ldval_r[n]);
      carry = hit;
    end
    if (runs_now(rti_tctrl_r))
      void'(count_down(rti_cval_r, rti_tflg_r, rti_ldval_r));
  endfunction

  function automatic bit in_ch_block(input logic [8:0] ofs);
    return ofs >= CH_BASE && ofs < CH_END;
  endfunction

  function automatic logic [31:0] read_reg(input logic [8:0] ofs, output logic bad);
    logic [31:0] rd;
    int n;
    rd = '0;
    bad = 1'b0;
    if (in_ch_block(ofs)) begin
      // block starts at 0x100 with 16-byte slots: bits 5:4 pick the channel
      n = int'(ofs[5:4]);
      case (ofs[3:0])
        REG_LDVAL: rd = ldval_r[n];
        REG_CVAL:  rd = cval_r[n];
        REG_TCTRL: rd = 32'(tctrl_r[n]);
        REG_TFLG:  rd = 32'(tflg_r[n]);
        default:   bad = 1'b1;
      endcase
    end else begin
      case (ofs)
        OFS_MCR:      rd = 32'(mcr_r);
        OFS_LTMR_HI: begin
          ltmr_latch_r = cval_r[0];
          rd = cval_r[1];
        end
        OFS_LTMR_LO:  rd = ltmr_latch_r;
        OFS_RSVD0, OFS_RSVD1: rd = '0;
        OFS_RTI_LD:   rd = rti_ldval_r;
        OFS_RTI_CV:   rd = rti_cval_r;
        OFS_RTI_CTRL: rd = 32'(rti_tctrl_r);
        OFS_RTI_FLG:  rd = 32'(rti_tflg_r);
        default:      bad = 1'b1;
      endcase
    end
    return rd;
  endfunction

  function automatic void write_reg(input logic [8:0] ofs, input logic [31:0] v,
                                    output logic bad);
    int n;
    bad = 1'b0;
    if (in_ch_block(ofs)) begin
      n = int'(ofs[5:4]);
      // holes and CVAL inside the channel block are dropped silently
      case (ofs[3:0])
        REG_LDVAL: begin
          ldval_r[n] = v;
          cval_r[n] = start_count(v);
        end
        REG_TCTRL: begin
          tctrl_r[n] = v[CTRL_W-1:0];
          if (v[BIT_TEN])
            tflg_r[n] = 1'b0;
          if (runs_now(tctrl_r[n]))
            cval_r[n] = start_count(ldval_r[n]);
        end
        REG_TFLG: tflg_r[n] = tflg_r[n] & ~v[0];
        default: ;
      endcase
    end else begin
      // outside the channel block only the reserved words take writes quietly
      case (ofs)
        OFS_MCR: begin
          mcr_r = v[CTRL_W-1:0];
          for (n = 0; n < NCH; n++)
            if (runs_now(tctrl_r[n]))
              cval_r[n] = start_count(ldval_r[n]);
        end
        OFS_RSVD0, OFS_RSVD1: ;
        OFS_RTI_LD: begin
          rti_ldval_r = v;
          // RTI load restarts on TEN alone, MDIS does not matter here
          if (rti_tctrl_r[BIT_TEN])
            rti_cval_r = start_count(v);
        end
        OFS_RTI_CTRL: begin
          rti_tctrl_r = v[CTRL_W-1:0];
          if (runs_now(rti_tctrl_r))
            rti_cval_r = start_count(rti_ldval_r);
        end
        OFS_RTI_FLG: rti_tflg_r = rti_tflg_r & ~v[0];
        default: bad = 1'b1;
      endcase
    end
  endfunction

  function automatic timer_result_t timer_predict(input bus_beat_t b);
    timer_result_t r;
    logic bad;
    int n;
    r = '0;
    bad = 1'b0;
    case (b.cmd)
      CMD_TICK:  tick_all();
      CMD_READ:  r.rdata = read_reg(b.ofs, bad);
      CMD_WRITE: write_reg(b.ofs, b.data, bad);
      default: ;
    endcase
    r.bad = bad;
    for (n = 0; n < NCH; n++)
      if (tctrl_r[n][BIT_TIE] && tflg_r[n])
        r.irq[n] = 1'b1;
    if (rti_tctrl_r[BIT_TIE] && rti_tflg_r)
      r.irq[0] = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_beat(input logic [1:0] c, input logic [8:0] ofs,
                                    input logic [31:0] v);
    bus_beat_t b;
    b.cmd = c;
    b.ofs = ofs;
    b.data = v;
    access_q.push_back(b);
  endfunction

  function automatic logic [8:0] ch_reg(input int n, input logic [3:0] sub);
    return CH_BASE + 9'(n * CH_STRIDE) + 9'(sub);
  endfunction

  // mostly real registers, some arbitrary offsets
  function automatic logic [8:0] pick_offset();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65)
      return ch_reg($urandom_range(NCH - 1), ch_regs[$urandom_range(3)]);
    if (sel < 88)
      return glob_regs[$urandom_range(8)];
    return 9'($urandom());
  endfunction

  // small loads so counters expire often; MCR mostly leaves the module enabled
  function automatic logic [31:0] pick_data(input logic [8:0] ofs);
    int sel;
    sel = $urandom_range(99);
    if (ofs == OFS_MCR)
      return (sel < 85) ? ($urandom() & ~(32'd1 << BIT_MDIS)) : $urandom();
    if ((in_ch_block(ofs) && ofs[3:0] == REG_LDVAL) || ofs == OFS_RTI_LD) begin
      if (sel < 10)
        return '0;
      if (sel < 15)
        return '1;
      if (sel < 20)
        return $urandom();
      return 32'($urandom_range(1, 6));
    end
    return $urandom();
  endfunction

  function automatic void push_random_access();
    int sel;
    logic [8:0] ofs;
    sel = $urandom_range(99);
    ofs = pick_offset();
    if (sel < 20)
      push_beat(CMD_TICK, ofs, $urandom());
    else if (sel < 55)
      push_beat(CMD_READ, ofs, $urandom());
    else if (sel < 97)
      push_beat(CMD_WRITE, ofs, pick_data(ofs));
    else
      push_beat(CMD_NONE, ofs, $urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time from access_q, with random idle bursts
  // ---------------------------------------------------------------------------
  bus_beat_t drv_beat;
  int src_gap = 0;

  always @(posedge clk) begin
    logic next_valid;
    bit idle_ok;
    next_valid = in_valid;
    if (rst) begin
      clear_timer();
      src_gap = 0;
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reply_q.push_back(timer_predict(drv_beat));
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        idle_ok = (total_beats - beats_loaded > QUIET_TAIL) && ((beats_loaded / 128) % 3 != 2);
        if (src_gap > 0) begin
          src_gap--;
          next_valid = 1'b0;
        end else if (idle_ok && access_q.size() > 0 && $urandom_range(99) < 15) begin
          src_gap = $urandom_range(1, 5) - 1;
          next_valid = 1'b0;
        end else if (access_q.size() > 0) begin
          drv_beat = access_q.pop_front();
          beats_loaded++;
          cmd <= drv_beat.cmd;
          reg_offset <= drv_beat.ofs;
          write_data <= drv_beat.data;
          next_valid = 1'b1;
        end else begin
          next_valid = 1'b0;
        end
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  int sink_gap = 0;

  always @(posedge clk) begin
    timer_result_t exp_r;
    bit idle_ok;
    if (rst) begin
      sink_gap = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          $error("read_data: no result expected, got %h", read_data);
          fail_cnt++;
        end else begin
          exp_r = reply_q.pop_front();
          if (read_data !== exp_r.rdata) begin
            $error("read_data: expected %h, actual %h", exp_r.rdata, read_data);
            fail_cnt++;
          end
          if (irq_lines !== exp_r.irq) begin
            $error("irq_lines: expected %h, actual %h", exp_r.irq, irq_lines);
            fail_cnt++;
          end
          if (unmapped !== exp_r.bad) begin
            $error("unmapped: expected %b, actual %b", exp_r.bad, unmapped);
            fail_cnt++;
          end
        end
      end
      idle_ok = (total_beats - replies_seen > QUIET_TAIL) && ((replies_seen / 128) % 3 != 1);
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (idle_ok && $urandom_range(99) < 15) begin
        sink_gap = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no beat moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    // directed: disabled module, zero and full loads, chaining, RTI, odd offsets
    push_beat(CMD_READ, OFS_MCR, '0);
    push_beat(CMD_WRITE, ch_reg(0, REG_LDVAL), '0);
    push_beat(CMD_WRITE, ch_reg(1, REG_LDVAL), '1);
    push_beat(CMD_WRITE, ch_reg(0, REG_TCTRL), '1);   // chain bit on channel 0
    push_beat(CMD_TICK, '0, '0);                      // still disabled
    push_beat(CMD_WRITE, OFS_MCR, 32'hFFFF_FFF9);     // enable, restarts channel 0
    push_beat(CMD_TICK, '1, '1);
    push_beat(CMD_WRITE, ch_reg(1, REG_TCTRL), 32'h7);
    push_beat(CMD_TICK, '0, '0);
    push_beat(CMD_READ, OFS_LTMR_HI, '0);
    push_beat(CMD_READ, OFS_LTMR_LO, '0);
    push_beat(CMD_WRITE, ch_reg(0, REG_TFLG), '1);
    push_beat(CMD_WRITE, OFS_RTI_LD, '0);             // RTI off: no restart
    push_beat(CMD_WRITE, OFS_RTI_CTRL, 32'h3);
    push_beat(CMD_TICK, '0, '0);
    push_beat(CMD_READ, OFS_RTI_CV, '0);
    push_beat(CMD_WRITE, OFS_RTI_FLG, 32'h1);
    push_beat(CMD_READ, 9'h1FC, '0);
    push_beat(CMD_WRITE, 9'h004, 32'h1234_5678);
    push_beat(CMD_WRITE, ch_reg(1, REG_CVAL), 32'h5);
    push_beat(CMD_READ, ch_reg(3, REG_TFLG) + 9'd2, '0);
    push_beat(CMD_WRITE, OFS_RSVD0, '1);
    push_beat(CMD_WRITE, OFS_LTMR_LO, '1);
    push_beat(CMD_NONE, OFS_MCR, '1);
    push_beat(CMD_READ, ch_reg(3, REG_TCTRL), '0);

    // random: bursts of ticks between register traffic
    while (access_q.size() < NUM_BEATS) begin
      if ($urandom_range(99) < 25) begin
        k = $urandom_range(1, 8);
        repeat (k) push_beat(CMD_TICK, 9'($urandom()), $urandom());
      end else begin
        push_random_access();
      end
    end
    total_beats = access_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken < total_beats || reply_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== periodic_interrupt_timer_4ch.f =====
+incdir+src
src/pit4_pkg.sv
src/periodic_interrupt_timer_4ch.sv
src/pit4_checker.sv
test/periodic_interrupt_timer_4ch_test.sv
